[design/lew_pkg.sv]
package lew_pkg;

	localparam int KIND_W  = 3;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 6;

	localparam logic [KIND_W-1:0] KIND_ECHO    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BELL    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERASE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TERM    = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_EOT   = 8'd4;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_NAK   = 8'd21;
	localparam logic [CHAR_W-1:0] CH_ETB   = 8'd23;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'd126;
	localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  chr;
		logic [COUNT_W-1:0] cnt;
		logic               last;
	} res_t;

	function automatic logic is_sep(input logic [CHAR_W-1:0] ch);
		return (ch == CH_SPACE) || (ch == CH_TAB);
	endfunction

	function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
			input logic [CHAR_W-1:0] ch, input logic [COUNT_W-1:0] cnt,
			input logic last);
		res_t r;
		r.kind = kind;
		r.chr  = ch;
		r.cnt  = cnt;
		r.last = last;
		return r;
	endfunction

endpackage

[design/lew_store.sv]
module lew_store import lew_pkg::*; #(
	parameter int DEPTH = 40,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CHAR_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/lew_ctrl.sv]
module lew_ctrl import lew_pkg::*; #(
	parameter int LINE_WIDTH = 40,
	parameter int AW         = 6,
	parameter int CW         = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] in_byte,
	input  logic              slot_free,
	output logic              emit,
	output res_t              res,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output logic [CHAR_W-1:0] wdata,
	output logic [AW-1:0]     raddr,
	input  logic [CHAR_W-1:0] rdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EMIT  = 3'd1;
	localparam logic [2:0] S_WSEP  = 3'd2;
	localparam logic [2:0] S_WWORD = 3'd3;
	localparam logic [2:0] S_ZSCAN = 3'd4;
	localparam logic [2:0] S_COPY  = 3'd5;

	localparam logic [CW-1:0] LW  = CW'(LINE_WIDTH);
	localparam logic [CW-1:0] ONE = CW'(1);

	logic [2:0]    state_q, state_d, after_q, after_d;
	logic [CW-1:0] cur_q, cur_d, p_q, p_d, p_inc, p_dec, cur_inc, w_cnt;
	logic [AW-1:0] d_q, d_d;
	logic          halt_q, halt_d;
	res_t          pend_q, pend_d;

	assign p_inc   = p_q + ONE;
	assign p_dec   = p_q - ONE;
	assign cur_inc = cur_q + ONE;
	assign w_cnt   = cur_q - p_q;
	assign in_ready = (state_q == S_IDLE);

	// the store is read at p-1 of the next pointer (at 0 when that pointer is 0), so rdata holds entry p-1
	assign raddr = (p_d == '0) ? '0 : AW'(p_d - ONE);

	always_comb begin
		state_d = state_q;
		after_d = after_q;
		cur_d   = cur_q;
		p_d     = p_q;
		d_d     = d_q;
		halt_d  = halt_q;
		pend_d  = pend_q;
		we      = 1'b0;
		waddr   = d_q;
		wdata   = in_byte;
		emit    = 1'b0;
		res     = pend_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !halt_q) begin
					after_d = S_IDLE;
					priority if (in_byte == CH_EOT) begin
						if (cur_q == '0) begin
							pend_d  = mk_res(KIND_TERM, CH_NUL, '0, 1'b1);
							halt_d  = 1'b1;
							state_d = S_EMIT;
						end
					end else if (in_byte == CH_BS || in_byte == CH_DEL) begin
						if (cur_q != '0) begin
							cur_d   = cur_q - ONE;
							pend_d  = mk_res(KIND_ERASE, CH_NUL, COUNT_W'(1), 1'b1);
							state_d = S_EMIT;
						end
					end else if (in_byte == CH_NAK) begin
						if (cur_q != '0) begin
							pend_d  = mk_res(KIND_ERASE, CH_NUL, COUNT_W'(cur_q), 1'b1);
							cur_d   = '0;
							state_d = S_EMIT;
						end
					end else if (in_byte == CH_ETB) begin
						p_d     = cur_q;
						state_d = S_WSEP;
					end else if (in_byte == CH_LF || in_byte == CH_CR) begin
						pend_d  = mk_res(KIND_NEWLINE, CH_NUL, '0, 1'b1);
						cur_d   = '0;
						state_d = S_EMIT;
					end else if (in_byte < CH_SPACE || in_byte > CH_TILDE) begin
						pend_d  = mk_res(KIND_BELL, CH_NUL, '0, 1'b1);
						state_d = S_EMIT;
					end else if (cur_q != LW) begin
						we      = 1'b1;
						waddr   = AW'(cur_q);
						cur_d   = cur_inc;
						p_d     = cur_inc;
						pend_d  = mk_res(KIND_ECHO, in_byte, '0, cur_inc != LW);
						after_d = (cur_inc == LW) ? S_ZSCAN : S_IDLE;
						state_d = S_EMIT;
					end else begin
						pend_d  = mk_res(KIND_BELL, CH_NUL, '0, 1'b1);
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = after_q;
				end
			end
			S_WSEP, S_WWORD: begin
				// ctrl-w: skip trailing separators, then the word before them
				if (p_q == '0 || (state_q == S_WWORD && is_sep(rdata))) begin
					cur_d = p_q;
					if (w_cnt != '0) begin
						pend_d  = mk_res(KIND_ERASE, CH_NUL, COUNT_W'(w_cnt), 1'b1);
						after_d = S_IDLE;
						state_d = S_EMIT;
					end else begin
						state_d = S_IDLE;
					end
				end else if (state_q == S_WSEP && !is_sep(rdata)) begin
					state_d = S_WWORD;
				end else begin
					p_d = p_dec;
				end
			end
			S_ZSCAN: begin
				// find the start of the partial last word on a full line
				if (p_q == '0 || is_sep(rdata)) begin
					if (p_q == '0 || p_q == LW) begin
						pend_d  = mk_res(KIND_NEWLINE, CH_NUL, '0, 1'b1);
						cur_d   = '0;
						after_d = S_IDLE;
					end else begin
						pend_d  = mk_res(KIND_NEWLINE, CH_NUL, '0, 1'b0);
						cur_d   = LW - p_q;
						p_d     = p_inc;
						d_d     = '0;
						after_d = S_COPY;
					end
					state_d = S_EMIT;
				end else begin
					p_d = p_dec;
				end
			end
			S_COPY: begin
				// move one char of the word down and echo it again
				if (slot_free) begin
					emit  = 1'b1;
					res   = mk_res(KIND_ECHO, rdata, '0, p_q == LW);
					we    = 1'b1;
					waddr = d_q;
					wdata = rdata;
					if (p_q == LW) begin
						state_d = S_IDLE;
					end else begin
						p_d = p_inc;
						d_d = d_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			cur_q   <= '0;
			halt_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
			cur_q   <= cur_d;
			halt_q  <= halt_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q    <= p_d;
		d_q    <= d_d;
		pend_q <= pend_d;
	end

endmodule

[design/line_editor_with_word_wrap_unit.sv]
// channel  direction  handshake             word
// in       input      in_valid / in_ready   in_byte
// out      output     out_valid / out_ready out_kind, out_char, erase_count, last
//
// a byte is taken only while the sequencer is idle
// ctrl-w walks back over the line, one store read per cycle
// a wrap walks back over the last word and re-echoes it, one char a cycle
// while the out port takes them; the walk back does one store read a cycle
// reset clears cursor and halt flag; the line store is not cleared
// a stalled out port holds the sequencer; the result register frees on take
module line_editor_with_word_wrap_unit import lew_pkg::*; #(
	parameter int LINE_WIDTH = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CHAR_W-1:0]  in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [KIND_W-1:0]  out_kind,
	output logic [CHAR_W-1:0]  out_char,
	output logic [COUNT_W-1:0] erase_count,
	output logic               last
);

	localparam int AW = $clog2(LINE_WIDTH);
	localparam int CW = $clog2(LINE_WIDTH + 1);

	logic              slot_free, emit, we;
	res_t              res, out_q;
	logic              out_valid_q;
	logic [AW-1:0]     waddr, raddr;
	logic [CHAR_W-1:0] wdata, rdata;

	assign slot_free = !out_valid_q || out_ready;

	lew_ctrl #(
		.LINE_WIDTH(LINE_WIDTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.slot_free(slot_free),
		.emit(emit),
		.res(res),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	lew_store #(
		.DEPTH(LINE_WIDTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_q.kind;
	assign out_char    = out_q.chr;
	assign erase_count = out_q.cnt;
	assign last        = out_q.last;

endmodule
